/* design/foc_clarke_park_transform_top_macros.svh */
// Assertion macros for the Clarke/Park transform block.
// No dependencies; included by the port checker.
`ifndef FOC_CLARKE_PARK_TRANSFORM_TOP_MACROS_SVH
`define FOC_CLARKE_PARK_TRANSFORM_TOP_MACROS_SVH

// Checked on every rising edge of clk while out of reset.
`define CPT_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define CPT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/cpt_pkg.sv */
// Shared types, constants and rounding helpers for the Clarke/Park transform.
// No dependencies; used by every module of the block.
package cpt_pkg;

    localparam int SAMPLE_WIDTH = 16;          // data sample width, Q1.(SAMPLE_WIDTH-1)
    localparam int ANGLE_WIDTH  = 16;          // sine/cosine, Q1.15
    localparam int FRAC_BITS    = 15;          // fraction bits of all coefficients

    localparam int NUM_MUL  = 4;               // multipliers per product stage
    localparam int MUL_A_W  = SAMPLE_WIDTH + 2;    // holds u - 2v + w
    localparam int MUL_B_W  = ANGLE_WIDTH;         // angle or coefficient
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int RND_W    = SUM_W - FRAC_BITS;
    localparam int LATENCY  = 4;               // start to done, in cycles

    localparam logic signed [MUL_B_W-1:0] C_ONE_THIRD  = MUL_B_W'(10923);
    localparam logic signed [MUL_B_W-1:0] C_INV_SQRT3  = MUL_B_W'(18919);
    localparam logic signed [MUL_B_W-1:0] C_HALF       = MUL_B_W'(16384);
    localparam logic signed [MUL_B_W-1:0] C_SQRT3_HALF = MUL_B_W'(28378);

    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

    typedef enum logic {
        OP_FORWARD = 1'b0,
        OP_INVERSE = 1'b1
    } cpt_op_t;

    typedef struct packed {
        cpt_op_t                         operation;
        logic signed [ANGLE_WIDTH-1:0]   sine;
        logic signed [ANGLE_WIDTH-1:0]   cosine;
        logic signed [SAMPLE_WIDTH-1:0]  first_in;
        logic signed [SAMPLE_WIDTH-1:0]  second_in;
        logic signed [SAMPLE_WIDTH-1:0]  third_in;
    } cpt_in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0]  first_out;
        logic signed [SAMPLE_WIDTH-1:0]  second_out;
        logic signed [SAMPLE_WIDTH-1:0]  third_out;
        logic signed [SAMPLE_WIDTH-1:0]  alpha_out;
        logic signed [SAMPLE_WIDTH-1:0]  beta_out;
    } cpt_out_t;

    // operand pairs for one product stage
    typedef struct packed {
        logic [NUM_MUL-1:0][MUL_A_W-1:0] opa;
        logic [NUM_MUL-1:0][MUL_B_W-1:0] opb;
    } cpt_mul_in_t;

    typedef logic [NUM_MUL-1:0][PROD_W-1:0] cpt_prod_t;

    // side data that rides along with the products
    typedef struct packed {
        cpt_op_t                         operation;
        logic signed [ANGLE_WIDTH-1:0]   sine;
        logic signed [ANGLE_WIDTH-1:0]   cosine;
        logic signed [SAMPLE_WIDTH-1:0]  alpha;
        logic signed [SAMPLE_WIDTH-1:0]  beta;
    } cpt_tag_t;

    // floor(v / 2^FRAC_BITS + 1/2), saturated to the sample range
    function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] t;
        logic signed [RND_W-1:0] r;
        logic signed [SAMPLE_WIDTH-1:0] res;
        t = v + ROUND_HALF;
        r = $signed(t[SUM_W-1:FRAC_BITS]);
        if (r > RND_W'(S_MAX))
            res = S_MAX;
        else if (r < RND_W'(S_MIN))
            res = S_MIN;
        else
            res = SAMPLE_WIDTH'(r);
        return res;
    endfunction

    // -v with the most negative value mapped to the maximum
    function automatic logic signed [SAMPLE_WIDTH-1:0] neg_sat(
        input logic signed [SAMPLE_WIDTH-1:0] v
    );
        logic signed [SAMPLE_WIDTH-1:0] res;
        if (v == S_MIN)
            res = S_MAX;
        else
            res = -v;
        return res;
    endfunction

endpackage

/* design/cpt_mul4.sv */
// One product stage: four signed multipliers with registered products.
// Depends on cpt_pkg.
module cpt_mul4
    import cpt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  cpt_mul_in_t  in_op,
    input  cpt_tag_t     in_tag,
    output logic         out_valid,
    output cpt_prod_t    out_prod,
    output cpt_tag_t     out_tag
);

    logic       valid_reg;
    cpt_prod_t  prod_reg;
    cpt_prod_t  prod_next;
    cpt_tag_t   tag_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_MUL; i++)
        begin
            prod_next[i] = PROD_W'($signed(in_op.opa[i]) * $signed(in_op.opb[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // payload loads with valid only
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg <= prod_next;
            tag_reg  <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;
    assign out_tag   = tag_reg;

endmodule

/* design/foc_clarke_park_transform_top.sv */
// Clarke/Park transform and inverse, fixed point, four-stage pipeline.
// Depends on cpt_pkg and cpt_mul4.
//
//  channel | handshake                   | word
//  --------+-----------------------------+----------------------------------
//  command | start in, busy out          | cmd    (cpt_in_t): op, sin, cos, 3 samples
//  result  | done out, one-cycle strobe  | result (cpt_out_t): 3 outputs, alpha, beta
//
// A command word is taken on every edge with start high and busy low; busy
// is never raised, so one word per cycle is sustained.
// Results appear in the order of their commands; each command passes through
// two multiply stages and two round/saturate stages.
// Reset clears only the valid bits; no result strobes until a word goes in.
// The receiver cannot stall, so nothing is ever held back.
//
// Stages:
//   1  multiply: forward (u-2v+w)*1/3 and (u-w)*1/sqrt3, inverse d*cos,
//      q*sin, d*sin, q*cos
//   2  sum, round half up, saturate -> alpha, beta
//   3  multiply: rotation by the angle (forward) or projection onto the
//      phase axes (inverse)
//   4  sum, round, saturate -> output register
module foc_clarke_park_transform_top
    import cpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  cpt_in_t   cmd,
    output logic      done,
    output cpt_out_t  result
);

    // ---- stage 1 operands ----------------------------------------------
    logic                      accept;
    logic signed [MUL_A_W-1:0] x_ext;
    logic signed [MUL_A_W-1:0] y_ext;
    logic signed [MUL_A_W-1:0] z_ext;
    cpt_mul_in_t               s1_op;
    cpt_tag_t                  s1_tag;

    logic       m1_valid;
    cpt_prod_t  m1_prod;
    cpt_tag_t   m1_tag;

    // ---- stage 2 ---------------------------------------------------------
    logic                    s2_valid_reg;
    cpt_tag_t                s2_tag_reg;
    cpt_tag_t                s2_tag_next;
    logic signed [SUM_W-1:0] s2_sum_a;
    logic signed [SUM_W-1:0] s2_sum_b;

    // ---- stage 3 ---------------------------------------------------------
    logic signed [MUL_A_W-1:0] a_ext;
    logic signed [MUL_A_W-1:0] b_ext;
    cpt_mul_in_t               s3_op;

    logic       m3_valid;
    cpt_prod_t  m3_prod;
    cpt_tag_t   m3_tag;

    // ---- stage 4 ---------------------------------------------------------
    logic                    done_reg;
    cpt_out_t                result_reg;
    cpt_out_t                result_next;
    logic signed [SUM_W-1:0] s4_sum_p;
    logic signed [SUM_W-1:0] s4_sum_m;
    logic signed [SUM_W-1:0] s4_sum_q;

    // Fully pipelined: never refuses a word.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stage 1: choose multiplier operands by operation.
    // The alpha product sits in slots 0/1 (slot0 - slot1), beta in 2/3 (sum).
    always_comb
    begin
        x_ext = MUL_A_W'(cmd.first_in);
        y_ext = MUL_A_W'(cmd.second_in);
        z_ext = MUL_A_W'(cmd.third_in);

        s1_op = '0;
        case (cmd.operation)
            OP_FORWARD:
            begin
                s1_op.opa[0] = x_ext - (y_ext <<< 1) + z_ext;
                s1_op.opb[0] = C_ONE_THIRD;
                s1_op.opa[2] = x_ext - z_ext;
                s1_op.opb[2] = C_INV_SQRT3;
            end
            OP_INVERSE:
            begin
                s1_op.opa[0] = x_ext;
                s1_op.opb[0] = cmd.cosine;
                s1_op.opa[1] = y_ext;
                s1_op.opb[1] = cmd.sine;
                s1_op.opa[2] = x_ext;
                s1_op.opb[2] = cmd.sine;
                s1_op.opa[3] = y_ext;
                s1_op.opb[3] = cmd.cosine;
            end
            default:
            begin
                s1_op = '0;
            end
        endcase

        s1_tag           = '0;
        s1_tag.operation = cmd.operation;
        s1_tag.sine      = cmd.sine;
        s1_tag.cosine    = cmd.cosine;
    end

    cpt_mul4 u_mul_ab (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_op     (s1_op),
        .in_tag    (s1_tag),
        .out_valid (m1_valid),
        .out_prod  (m1_prod),
        .out_tag   (m1_tag)
    );

    // Stage 2: alpha = rs(p0 - p1), beta = rs(p2 + p3).
    always_comb
    begin
        s2_sum_a = SUM_W'($signed(m1_prod[0])) - SUM_W'($signed(m1_prod[1]));
        s2_sum_b = SUM_W'($signed(m1_prod[2])) + SUM_W'($signed(m1_prod[3]));
        s2_tag_next       = m1_tag;
        s2_tag_next.alpha = round_sat(s2_sum_a);
        s2_tag_next.beta  = round_sat(s2_sum_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= m1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (m1_valid)
            s2_tag_reg <= s2_tag_next;
    end

    // Stage 3 operands.
    // forward: a*cos, b*sin, b*cos, a*sin
    // inverse: a*1/2, b*sqrt3/2 (slots 2/3 unused)
    always_comb
    begin
        a_ext = MUL_A_W'(s2_tag_reg.alpha);
        b_ext = MUL_A_W'(s2_tag_reg.beta);

        s3_op = '0;
        case (s2_tag_reg.operation)
            OP_FORWARD:
            begin
                s3_op.opa[0] = a_ext;
                s3_op.opb[0] = s2_tag_reg.cosine;
                s3_op.opa[1] = b_ext;
                s3_op.opb[1] = s2_tag_reg.sine;
                s3_op.opa[2] = b_ext;
                s3_op.opb[2] = s2_tag_reg.cosine;
                s3_op.opa[3] = a_ext;
                s3_op.opb[3] = s2_tag_reg.sine;
            end
            OP_INVERSE:
            begin
                s3_op.opa[0] = a_ext;
                s3_op.opb[0] = C_HALF;
                s3_op.opa[1] = b_ext;
                s3_op.opb[1] = C_SQRT3_HALF;
            end
            default:
            begin
                s3_op = '0;
            end
        endcase
    end

    cpt_mul4 u_mul_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_op     (s3_op),
        .in_tag    (s2_tag_reg),
        .out_valid (m3_valid),
        .out_prod  (m3_prod),
        .out_tag   (m3_tag)
    );

    // Stage 4: final sums, rounding and saturation.
    always_comb
    begin
        s4_sum_p = SUM_W'($signed(m3_prod[0])) + SUM_W'($signed(m3_prod[1]));
        s4_sum_m = SUM_W'($signed(m3_prod[0])) - SUM_W'($signed(m3_prod[1]));
        s4_sum_q = SUM_W'($signed(m3_prod[2])) - SUM_W'($signed(m3_prod[3]));

        result_next.first_out = round_sat(s4_sum_p);
        result_next.alpha_out = m3_tag.alpha;
        result_next.beta_out  = m3_tag.beta;
        case (m3_tag.operation)
            OP_FORWARD:
            begin
                result_next.second_out = round_sat(s4_sum_q);
                result_next.third_out  = '0;
            end
            OP_INVERSE:
            begin
                // v = -alpha, saturating
                result_next.second_out = neg_sat(m3_tag.alpha);
                result_next.third_out  = round_sat(s4_sum_m);
            end
            default:
            begin
                result_next.second_out = '0;
                result_next.third_out  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= m3_valid;
    end

    always_ff @(posedge clk)
    begin
        if (m3_valid)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* design/cpt_port_checker.sv */
// Port-level checks for the Clarke/Park transform, bound to the top level.
// Depends on cpt_pkg and foc_clarke_park_transform_top_macros.svh.
`include "foc_clarke_park_transform_top_macros.svh"

module cpt_port_checker
    import cpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  cpt_in_t   cmd,
    input  logic      done,
    input  cpt_out_t  result
);

    logic take;
    logic take_fwd;
    logic take_inv;
    logic third_zero;
    logic inv_v_ok;

    assign take       = start && !busy;
    assign take_fwd   = take && (cmd.operation == OP_FORWARD);
    assign take_inv   = take && (cmd.operation == OP_INVERSE);
    assign third_zero = (result.third_out == '0);
    // v is the saturated negation of alpha
    assign inv_v_ok   = (result.alpha_out == S_MIN) ? (result.second_out == S_MAX)
                                                    : (result.second_out == -result.alpha_out);

    // every accepted word produces a result after the fixed latency
    `CPT_ASSERT_CLK(a_done_follows, take |-> ##LATENCY done, "missing result")

    // no result without a word accepted the fixed latency earlier
    `CPT_ASSERT_CLK(a_no_extra, done |-> $past(take, LATENCY), "unexpected result")

    // forward transform leaves the third output at zero
    `CPT_ASSERT_CLK(a_fwd_third, take_fwd |-> ##LATENCY third_zero, "forward third_out not zero")

    // inverse: v is the saturated negation of alpha
    `CPT_ASSERT_CLK(a_inv_v, take_inv |-> ##LATENCY inv_v_ok, "inverse v mismatch")

endmodule

bind foc_clarke_park_transform_top cpt_port_checker u_cpt_port_checker (.*);

/* tb/sv/tb_foc_clarke_park_transform_top.sv */
// Self-checking testbench for the Clarke/Park transform block.
// Depends on cpt_pkg and the foc_clarke_park_transform_top RTL. Scoreboard class and
// driver tasks live here; nothing else is read.
`timescale 1ns / 100ps

module tb_foc_clarke_park_transform_top;
    import cpt_pkg::*;

    // Q1.15 coefficients the block is meant to use
    localparam longint K_ONE_THIRD  = 10923;
    localparam longint K_INV_SQRT3  = 18919;
    localparam longint K_HALF       = 16384;
    localparam longint K_SQRT3_HALF = 28378;
    localparam int     DRAIN_LIMIT  = 1000;     // cycles allowed for the tail to empty
    localparam real    TWO_PI       = 6.283185307179586;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    // ------------------------------------------------------------------
    // Scoreboard: turns every accepted command word into the expected
    // result word and checks the result words in order against them.
    // ------------------------------------------------------------------
    class transform_checker;
        cpt_out_t pending_results[$];
        int       fail_count;

        function new();
            fail_count = 0;
        endfunction

        // clamp to the signed sample range
        function sample_t clip_sample(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
                return sample_t'(hi);
            if (v < lo)
                return sample_t'(lo);
            return sample_t'(v);
        endfunction

        // drop 15 fraction bits, round half up, saturate
        function sample_t round_q15(longint v);
            return clip_sample((v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        endfunction

        function cpt_out_t transform_word(cpt_in_t w);
            cpt_out_t r;
            longint   s;
            longint   c;
            longint   x;
            longint   y;
            longint   z;
            longint   a;
            longint   b;
            s = $signed(w.sine);
            c = $signed(w.cosine);
            x = $signed(w.first_in);
            y = $signed(w.second_in);
            z = $signed(w.third_in);
            if (w.operation == OP_FORWARD)
            begin
                // Clarke, then Park; third output is always zero
                r.alpha_out  = round_q15((x - 2 * y + z) * K_ONE_THIRD);
                r.beta_out   = round_q15((x - z) * K_INV_SQRT3);
                a = $signed(r.alpha_out);
                b = $signed(r.beta_out);
                r.first_out  = round_q15(a * c + b * s);
                r.second_out = round_q15(b * c - a * s);
                r.third_out  = '0;
            end
            else
            begin
                // inverse Park, then inverse Clarke; third input plays no part
                r.alpha_out  = round_q15(x * c - y * s);
                r.beta_out   = round_q15(x * s + y * c);
                a = $signed(r.alpha_out);
                b = $signed(r.beta_out);
                r.first_out  = round_q15(a * K_HALF + b * K_SQRT3_HALF);
                r.second_out = clip_sample(-a);   // -min saturates to max
                r.third_out  = round_q15(a * K_HALF - b * K_SQRT3_HALF);
            end
            return r;
        endfunction

        function void note_command(cpt_in_t w);
            pending_results.push_back(transform_word(w));
        endfunction

        function void compare_field(string name, sample_t want, sample_t got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(cpt_out_t got);
            cpt_out_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none actual %h", $time, got);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("first_out", want.first_out, got.first_out);
            compare_field("second_out", want.second_out, got.second_out);
            compare_field("third_out", want.third_out, got.third_out);
            compare_field("alpha_out", want.alpha_out, got.alpha_out);
            compare_field("beta_out", want.beta_out, got.beta_out);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cpt_in_t          cmd;
    logic             done;
    cpt_out_t         result;
    transform_checker chk;

    foc_clarke_park_transform_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: the receiver can never stall, so every done strobe is
    // a word taken at this edge. Sampled values are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && done)
            chk.check_result(result);
    end

    function automatic cpt_in_t make_word(cpt_op_t op, sample_t s, sample_t c,
                                          sample_t x, sample_t y, sample_t z);
        cpt_in_t w;
        w.operation = op;
        w.sine      = s;
        w.cosine    = c;
        w.first_in  = x;
        w.second_in = y;
        w.third_in  = z;
        return w;
    endfunction

    // pick from the corner values of a sample
    function automatic sample_t corner_sample();
        sample_t v;
        case ($urandom_range(4))
            0: v = S_MIN;
            1: v = S_MAX;
            2: v = '0;
            3: v = '1;
            default: v = sample_t'(1);
        endcase
        return v;
    endfunction

    // Random command word. Half are fully random bit patterns (covers every
    // bit and heavy saturation), a quarter are realistic: a unit-circle angle
    // with balanced three-phase or bounded d,q data; the rest mix corners.
    function automatic cpt_in_t random_word();
        cpt_in_t w;
        real     th;
        real     ph;
        real     amp;
        int      mode;
        th   = TWO_PI * $urandom_range(65535) / 65536.0;
        ph   = TWO_PI * $urandom_range(65535) / 65536.0;
        amp  = $urandom_range(32767);
        mode = $urandom_range(3);
        w.operation = ($urandom_range(1) != 0) ? OP_INVERSE : OP_FORWARD;
        if (mode < 2)
        begin
            w.sine      = sample_t'($urandom);
            w.cosine    = sample_t'($urandom);
            w.first_in  = sample_t'($urandom);
            w.second_in = sample_t'($urandom);
            w.third_in  = sample_t'($urandom);
        end
        else if (mode == 2)
        begin
            w.sine   = sample_t'(int'(32767.0 * $sin(th)));
            w.cosine = sample_t'(int'(32767.0 * $cos(th)));
            if (w.operation == OP_FORWARD)
            begin
                w.first_in  = sample_t'(int'(amp * $cos(ph)));
                w.second_in = sample_t'(int'(amp * $cos(ph - TWO_PI / 3.0)));
                w.third_in  = sample_t'(int'(amp * $cos(ph + TWO_PI / 3.0)));
            end
            else
            begin
                w.first_in  = sample_t'(int'(amp * $cos(ph)));
                w.second_in = sample_t'(int'(amp * $sin(ph)));
                w.third_in  = sample_t'($urandom);
            end
        end
        else
        begin
            w.sine      = corner_sample();
            w.cosine    = corner_sample();
            w.first_in  = corner_sample();
            w.second_in = corner_sample();
            w.third_in  = ($urandom_range(1) != 0) ? corner_sample() : sample_t'($urandom);
        end
        return w;
    endfunction

    // Present one command word and hold it until taken. start stays high
    // across back-to-back words, so it is never dropped and raised in one step.
    task automatic send_word(input cpt_in_t w);
        start <= 1'b1;
        cmd   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        chk.note_command(w);
    endtask

    // Geometric gap: each cycle idle with chance pct out of a hundred.
    task automatic sender_gap(input int pct);
        int gap;
        gap = 0;
        while ($urandom_range(99) < pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_phase(input int count, input int pct);
        for (int i = 0; i < count; i++)
        begin
            sender_gap(pct);
            send_word(random_word());
        end
    endtask

    // Hold the sender off until every outstanding result word has arrived.
    task automatic pause_until_empty();
        start <= 1'b0;
        @(posedge clk);
        while (chk.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        cpt_in_t directed[$];
        int      waited;
        chk   = new();
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: zero, full-scale corners, both operations,
        // alpha/beta saturation, -min on the v output, ignored third input.
        directed.push_back(make_word(OP_FORWARD, '0, '0, '0, '0, '0));
        directed.push_back(make_word(OP_INVERSE, '0, '0, '0, '0, '0));
        directed.push_back(make_word(OP_FORWARD, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
        directed.push_back(make_word(OP_FORWARD, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
        directed.push_back(make_word(OP_INVERSE, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
        directed.push_back(make_word(OP_INVERSE, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
        // alpha or beta past full scale in the forward path
        directed.push_back(make_word(OP_FORWARD, '0, S_MAX, S_MAX, S_MIN, S_MAX));
        directed.push_back(make_word(OP_FORWARD, S_MAX, S_MIN, S_MIN, S_MAX, S_MIN));
        directed.push_back(make_word(OP_FORWARD, S_MIN, S_MAX, S_MAX, S_MIN, S_MIN));
        // alpha pinned at min in inverse: v = -alpha must clamp to max
        directed.push_back(make_word(OP_INVERSE, S_MAX, S_MAX, S_MIN, S_MAX, '0));
        directed.push_back(make_word(OP_INVERSE, S_MIN, S_MIN, S_MAX, S_MIN, S_MAX));
        // same d,q with different third inputs: must give the same result
        directed.push_back(make_word(OP_INVERSE, 16'sd23170, 16'sd23170,
                                     16'sd10000, -16'sd5000, S_MIN));
        directed.push_back(make_word(OP_INVERSE, 16'sd23170, 16'sd23170,
                                     16'sd10000, -16'sd5000, S_MAX));
        // rounding at the half-LSB boundary, small magnitudes
        directed.push_back(make_word(OP_FORWARD, 16'sd1, 16'sd1, 16'sd1, -16'sd1, 16'sd1));
        directed.push_back(make_word(OP_INVERSE, -16'sd1, 16'sd1, -16'sd1, 16'sd1, '0));
        directed.push_back(make_word(OP_FORWARD, '0, S_MAX, 16'sd1, '0, -16'sd1));
        directed.push_back(make_word(OP_INVERSE, '0, S_MAX, 16'sd16384, '0, '0));
        directed.push_back(make_word(OP_INVERSE, S_MAX, '0, '0, 16'sd16384, '0));
        directed.push_back(make_word(OP_FORWARD, '1, '1, '1, '1, '1));
        directed.push_back(make_word(OP_INVERSE, '1, '1, '1, '1, '1));
        foreach (directed[i])
            send_word(directed[i]);

        // Random phases: back to back, sparse sender, a drained pause,
        // light gaps, then back to back again.
        run_phase(600, 0);
        run_phase(500, 87);
        pause_until_empty();
        run_phase(600, 12);
        run_phase(300, 0);
        start <= 1'b0;

        // Let the pipeline empty, bounded, then keep the sender idle to catch
        // any stray strobe.
        waited = 0;
        while (chk.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (chk.pending() != 0)
        begin
            $display("%0t: %0d result words never arrived, expected 0 left actual %0d",
                     $time, chk.pending(), chk.pending());
            chk.fail_count++;
        end
        repeat (LATENCY + 4) @(posedge clk);

        if (chk.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
